[hw/rtl/srf_pkg.sv]
`default_nettype none
package srf_pkg;

    localparam int OUT_W     = 32;
    localparam int MB_W      = 33;
    localparam int MUL_CHUNK = 24;
    localparam int PC_W      = 5;

    localparam logic [31:0] F_2PI_Q29 = 32'd3373259426;

    localparam int Q_NOTCH = 29;
    localparam int Q_KP    = 16;
    localparam int Q_FREQ  = 32;
    localparam int Q_PHASE = 19;

    localparam logic [2:0] REG_B0 = 3'd0;
    localparam logic [2:0] REG_B1 = 3'd1;
    localparam logic [2:0] REG_B2 = 3'd2;
    localparam logic [2:0] REG_A1 = 3'd3;
    localparam logic [2:0] REG_A2 = 3'd4;
    localparam logic [2:0] REG_KP = 3'd5;
    localparam logic [2:0] REG_KI = 3'd6;
    localparam logic [2:0] REG_HP = 3'd7;

    localparam logic [2:0] A_X  = 3'd0;
    localparam logic [2:0] A_D1 = 3'd1;
    localparam logic [2:0] A_D2 = 3'd2;
    localparam logic [2:0] A_Y1 = 3'd3;
    localparam logic [2:0] A_Y2 = 3'd4;
    localparam logic [2:0] A_T  = 3'd5;

    localparam logic [2:0] B_B0  = 3'd0;
    localparam logic [2:0] B_B1  = 3'd1;
    localparam logic [2:0] B_B2  = 3'd2;
    localparam logic [2:0] B_NA1 = 3'd3;
    localparam logic [2:0] B_NA2 = 3'd4;
    localparam logic [2:0] B_KP  = 3'd5;
    localparam logic [2:0] B_KI  = 3'd6;
    localparam logic [2:0] B_HP  = 3'd7;

    localparam logic [1:0] SH_NOTCH = 2'd0;
    localparam logic [1:0] SH_KP    = 2'd1;
    localparam logic [1:0] SH_FREQ  = 2'd2;
    localparam logic [1:0] SH_PHASE = 2'd3;

    localparam logic [3:0] ALU_NOP      = 4'd0;
    localparam logic [3:0] ALU_ACC_LOAD = 4'd1;
    localparam logic [3:0] ALU_ACC_ADD  = 4'd2;
    localparam logic [3:0] ALU_NOTCH    = 4'd3;
    localparam logic [3:0] ALU_KP       = 4'd4;
    localparam logic [3:0] ALU_FREQ     = 4'd5;
    localparam logic [3:0] ALU_VEL      = 4'd6;
    localparam logic [3:0] ALU_TPH      = 4'd7;
    localparam logic [3:0] ALU_PHASE    = 4'd8;
    localparam logic [3:0] ALU_SUB2PI   = 4'd9;
    localparam logic [3:0] ALU_ADD2PI   = 4'd10;
    localparam logic [3:0] ALU_RESTART  = 4'd11;
    localparam logic [3:0] ALU_OUT      = 4'd12;

    localparam logic [2:0] C_NONE   = 3'd0;
    localparam logic [2:0] C_ALWAYS = 3'd1;
    localparam logic [2:0] C_OP     = 3'd2;
    localparam logic [2:0] C_LT2PI  = 3'd3;
    localparam logic [2:0] C_NONNEG = 3'd4;

    localparam logic [PC_W-1:0] PC_NEGCHK  = 5'd14;
    localparam logic [PC_W-1:0] PC_OUT     = 5'd16;
    localparam logic [PC_W-1:0] PC_RESTART = 5'd17;
    localparam logic [PC_W-1:0] PC_NEXT    = 5'd0;

    typedef struct packed {
        logic                   op;
        logic signed [31:0]     sample;
    } t_in;

    typedef struct packed {
        logic signed [31:0]     frequency;
        logic [31:0]            phase;
        logic signed [31:0]     filtered_error;
    } t_out;

    typedef struct packed {
        logic                   mul_en;
        logic [2:0]             asel;
        logic [2:0]             bsel;
        logic [1:0]             shsel;
        logic [3:0]             alu;
        logic [2:0]             cond;
        logic [PC_W-1:0]        target;
    } t_uword;

    typedef struct packed {
        logic                   exec;
        logic                   mul_start;
        t_uword                 uw;
    } t_ctrl;

    typedef struct packed {
        logic                   op;
        logic                   lt2pi;
        logic                   nonneg;
        logic                   out_free;
        logic                   mul_done;
    } t_stat;

    function automatic t_uword mk_uw(input logic m, input logic [2:0] a, input logic [2:0] b,
                                     input logic [1:0] sh, input logic [3:0] alu,
                                     input logic [2:0] cond, input logic [PC_W-1:0] tgt);
        t_uword w;
        w.mul_en = m;
        w.asel   = a;
        w.bsel   = b;
        w.shsel  = sh;
        w.alu    = alu;
        w.cond   = cond;
        w.target = tgt;
        return w;
    endfunction

    // Item: notch taps, gain, two integrators, at most one phase wrap; op restarts.
    function automatic t_uword ucode_rom(input logic [PC_W-1:0] pc);
        t_uword w;
        case (pc)
            5'd0:  w = mk_uw(1'b0, A_X,  B_B0,  SH_NOTCH, ALU_NOP,      C_OP,     PC_RESTART);
            5'd1:  w = mk_uw(1'b1, A_X,  B_B0,  SH_NOTCH, ALU_ACC_LOAD, C_NONE,   PC_NEXT);
            5'd2:  w = mk_uw(1'b1, A_D1, B_B1,  SH_NOTCH, ALU_ACC_ADD,  C_NONE,   PC_NEXT);
            5'd3:  w = mk_uw(1'b1, A_D2, B_B2,  SH_NOTCH, ALU_ACC_ADD,  C_NONE,   PC_NEXT);
            5'd4:  w = mk_uw(1'b1, A_Y1, B_NA1, SH_NOTCH, ALU_ACC_ADD,  C_NONE,   PC_NEXT);
            5'd5:  w = mk_uw(1'b1, A_Y2, B_NA2, SH_NOTCH, ALU_ACC_ADD,  C_NONE,   PC_NEXT);
            5'd6:  w = mk_uw(1'b0, A_X,  B_B0,  SH_NOTCH, ALU_NOTCH,    C_NONE,   PC_NEXT);
            5'd7:  w = mk_uw(1'b1, A_Y1, B_KP,  SH_KP,    ALU_KP,       C_NONE,   PC_NEXT);
            5'd8:  w = mk_uw(1'b1, A_T,  B_KI,  SH_FREQ,  ALU_FREQ,     C_NONE,   PC_NEXT);
            5'd9:  w = mk_uw(1'b0, A_X,  B_B0,  SH_NOTCH, ALU_VEL,      C_NONE,   PC_NEXT);
            5'd10: w = mk_uw(1'b0, A_X,  B_B0,  SH_NOTCH, ALU_TPH,      C_NONE,   PC_NEXT);
            5'd11: w = mk_uw(1'b1, A_T,  B_HP,  SH_PHASE, ALU_PHASE,    C_NONE,   PC_NEXT);
            5'd12: w = mk_uw(1'b0, A_X,  B_B0,  SH_NOTCH, ALU_NOP,      C_LT2PI,  PC_NEGCHK);
            5'd13: w = mk_uw(1'b0, A_X,  B_B0,  SH_NOTCH, ALU_SUB2PI,   C_NONE,   PC_NEXT);
            5'd14: w = mk_uw(1'b0, A_X,  B_B0,  SH_NOTCH, ALU_NOP,      C_NONNEG, PC_OUT);
            5'd15: w = mk_uw(1'b0, A_X,  B_B0,  SH_NOTCH, ALU_ADD2PI,   C_NONE,   PC_NEXT);
            5'd16: w = mk_uw(1'b0, A_X,  B_B0,  SH_NOTCH, ALU_OUT,      C_NONE,   PC_NEXT);
            5'd17: w = mk_uw(1'b0, A_X,  B_B0,  SH_NOTCH, ALU_RESTART,  C_ALWAYS, PC_OUT);
            default: w = mk_uw(1'b0, A_X, B_B0, SH_NOTCH, ALU_NOP,      C_ALWAYS, PC_OUT);
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

[hw/rtl/srf_mul.sv]
`default_nettype none
module srf_mul import srf_pkg::*; #(
    parameter int ACC_WIDTH = 48
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic signed [ACC_WIDTH-1:0] i_a,
    input  wire logic signed [MB_W-1:0]      i_b,
    input  wire logic [1:0]                  i_sh,
    output logic                             o_done,
    output logic signed [ACC_WIDTH-1:0]      o_res
);

    localparam int NCH = (ACC_WIDTH + MUL_CHUNK - 1) / MUL_CHUNK;
    localparam int AW  = NCH * MUL_CHUNK;
    localparam int PW  = AW + MB_W;
    localparam int CW  = $clog2(NCH + 1);
    localparam logic signed [ACC_WIDTH-1:0] RMAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
    localparam logic signed [ACC_WIDTH-1:0] RMIN = ~RMAX;

    logic [AW-1:0]                  r_a;
    logic signed [MB_W-1:0]         r_b;
    logic [1:0]                     r_sh;
    logic signed [PW-1:0]           r_p;
    logic [CW-1:0]                  r_cnt;
    logic                           r_run;
    logic                           r_done;
    logic signed [ACC_WIDTH-1:0]    r_res;

    logic                           w_first;
    logic signed [MUL_CHUNK:0]      w_ca;
    logic signed [MUL_CHUNK+MB_W:0] w_pp;
    logic signed [PW-1:0]           w_base;
    logic signed [PW-1:0]           w_sum;
    logic signed [PW-1:0]           w_sh;
    logic [PW-ACC_WIDTH:0]          w_hi;
    logic signed [ACC_WIDTH-1:0]    w_sat;

    // The top chunk of the multiplicand goes first and carries its sign.
    always_comb begin
        w_first = (r_cnt == '0);
        w_ca    = signed'({w_first ? r_a[AW-1] : 1'b0, r_a[AW-1 -: MUL_CHUNK]});
        w_pp    = w_ca * r_b;
        w_base  = w_first ? '0 : (r_p <<< MUL_CHUNK);
        w_sum   = w_base + PW'(w_pp);
        case (r_sh)
            SH_NOTCH: w_sh = r_p >>> Q_NOTCH;
            SH_KP:    w_sh = r_p >>> Q_KP;
            SH_FREQ:  w_sh = r_p >>> Q_FREQ;
            SH_PHASE: w_sh = r_p >>> Q_PHASE;
            default:  w_sh = r_p >>> Q_NOTCH;
        endcase
        w_hi = w_sh[PW-1:ACC_WIDTH-1];
        if ((&w_hi) || !(|w_hi)) begin
            w_sat = w_sh[ACC_WIDTH-1:0];
        end else begin
            w_sat = w_sh[PW-1] ? RMIN : RMAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_run  <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_run) begin
            if (r_cnt == CW'(NCH)) begin
                r_run  <= 1'b0;
                r_done <= 1'b1;
            end else begin
                r_cnt <= r_cnt + CW'(1);
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a  <= AW'(i_a);
            r_b  <= i_b;
            r_sh <= i_sh;
        end else if (r_run) begin
            if (r_cnt != CW'(NCH)) begin
                r_p <= w_sum;
                r_a <= r_a << MUL_CHUNK;
            end else begin
                r_res <= w_sat;
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_run)
        else $error("multiply started while one is still running");

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("multiply done held for more than one cycle");

endmodule
`default_nettype wire

[hw/rtl/srf_dpath.sv]
`default_nettype none
module srf_dpath import srf_pkg::*; #(
    parameter int DATA_WIDTH = 32,
    parameter int ACC_WIDTH  = 48
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic        i_in_accept,
    input  wire t_in         i_in_data,
    input  wire t_ctrl       i_ctrl,
    input  wire logic        i_out_stall,
    output t_stat            o_stat,
    output logic             o_out_valid,
    output t_out             o_out_data
);

    localparam int AW = ACC_WIDTH;
    localparam int DW = DATA_WIDTH;
    localparam int WW = (AW > DW) ? AW : DW;
    localparam int YW = (DW > OUT_W) ? DW : OUT_W;
    localparam int EW = AW + 2;
    localparam int PE = AW + 1;

    localparam logic signed [AW-1:0] AMAX = {1'b0, {(AW-1){1'b1}}};
    localparam logic signed [AW-1:0] AMIN = ~AMAX;
    localparam logic [WW-1:0] DMAX_U = {1'b0, {(WW-1){1'b1}}} >> (WW - DW);
    localparam logic signed [WW-1:0] DMAX = signed'(DMAX_U);
    localparam logic signed [WW-1:0] DMIN = ~DMAX;
    localparam logic [AW-1:0] FMAX_U = {1'b0, {(AW-1){1'b1}}} >> (AW - OUT_W);
    localparam logic signed [AW-1:0] FMAX = signed'(FMAX_U);
    localparam logic signed [AW-1:0] FMIN = ~FMAX;
    localparam logic [YW-1:0] YMAX_U = {1'b0, {(YW-1){1'b1}}} >> (YW - OUT_W);
    localparam logic signed [YW-1:0] YMAX = signed'(YMAX_U);
    localparam logic signed [YW-1:0] YMIN = ~YMAX;
    localparam logic [PE-1:0] PMAX_U = {PE{1'b1}} >> (PE - OUT_W);
    localparam logic signed [PE-1:0] PMAX = signed'(PMAX_U);
    localparam logic signed [EW-1:0] TWO_PI = signed'(EW'(F_2PI_Q29));

    function automatic logic signed [AW-1:0] sat_add(input logic signed [AW-1:0] a,
                                                     input logic signed [AW-1:0] b);
        logic signed [AW:0] s;
        s = (AW+1)'(a) + (AW+1)'(b);
        if (s[AW] != s[AW-1]) begin
            return s[AW] ? AMIN : AMAX;
        end
        return s[AW-1:0];
    endfunction

    function automatic logic signed [AW-1:0] clamp_e(input logic signed [EW-1:0] v);
        logic [2:0] hi;
        hi = v[EW-1:AW-1];
        if ((&hi) || !(|hi)) begin
            return v[AW-1:0];
        end
        return v[EW-1] ? AMIN : AMAX;
    endfunction

    logic signed [31:0]     r_b0, r_b1, r_b2, r_a1, r_a2;
    logic [31:0]            r_kp, r_ki, r_hp;
    logic                   r_op;
    logic signed [31:0]     r_x;
    logic signed [31:0]     r_d1, r_d2;
    logic signed [DW-1:0]   r_y1, r_y2;
    logic signed [AW-1:0]   r_fprev, r_facc, r_pprev, r_pacc;
    logic signed [AW-1:0]   r_acc, r_kpin, r_t, r_v;
    logic                   r_out_valid;
    t_out                   r_out;

    logic signed [AW-1:0]   w_a;
    logic signed [MB_W-1:0] w_b;
    logic                   w_mdone;
    logic signed [AW-1:0]   w_m;
    logic signed [WW-1:0]   w_acc_w;
    logic signed [DW-1:0]   w_ynew;
    logic signed [EW-1:0]   w_pacc_e;
    logic signed [AW-1:0]   w_psub, w_padd;
    logic signed [31:0]     w_fq;
    logic signed [YW-1:0]   w_ye;
    logic signed [31:0]     w_yq;
    logic signed [PE-1:0]   w_pe;
    logic [31:0]            w_pq;
    logic                   w_out_free;
    logic                   w_do_out;

    always_comb begin
        case (i_ctrl.uw.asel)
            A_X:     w_a = AW'(r_x);
            A_D1:    w_a = AW'(r_d1);
            A_D2:    w_a = AW'(r_d2);
            A_Y1:    w_a = AW'(r_y1);
            A_Y2:    w_a = AW'(r_y2);
            A_T:     w_a = r_t;
            default: w_a = '0;
        endcase
        case (i_ctrl.uw.bsel)
            B_B0:    w_b = MB_W'(r_b0);
            B_B1:    w_b = MB_W'(r_b1);
            B_B2:    w_b = MB_W'(r_b2);
            B_NA1:   w_b = -MB_W'(r_a1);
            B_NA2:   w_b = -MB_W'(r_a2);
            B_KP:    w_b = signed'({1'b0, r_kp});
            B_KI:    w_b = signed'({1'b0, r_ki});
            B_HP:    w_b = signed'({1'b0, r_hp});
            default: w_b = '0;
        endcase
    end

    srf_mul #(
        .ACC_WIDTH (ACC_WIDTH)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_ctrl.mul_start),
        .i_a     (w_a),
        .i_b     (w_b),
        .i_sh    (i_ctrl.uw.shsel),
        .o_done  (w_mdone),
        .o_res   (w_m)
    );

    always_comb begin
        w_acc_w = WW'(r_acc);
        if (w_acc_w > DMAX) begin
            w_ynew = DMAX[DW-1:0];
        end else if (w_acc_w < DMIN) begin
            w_ynew = DMIN[DW-1:0];
        end else begin
            w_ynew = w_acc_w[DW-1:0];
        end

        w_pacc_e = EW'(r_pacc);
        w_psub   = clamp_e(w_pacc_e - TWO_PI);
        w_padd   = clamp_e(w_pacc_e + TWO_PI);

        if (r_facc > FMAX) begin
            w_fq = FMAX[31:0];
        end else if (r_facc < FMIN) begin
            w_fq = FMIN[31:0];
        end else begin
            w_fq = r_facc[31:0];
        end

        w_ye = YW'(r_y1);
        if (w_ye > YMAX) begin
            w_yq = YMAX[31:0];
        end else if (w_ye < YMIN) begin
            w_yq = YMIN[31:0];
        end else begin
            w_yq = w_ye[31:0];
        end

        w_pe = PE'(r_pacc);
        if (w_pe[PE-1]) begin
            w_pq = '0;
        end else if (w_pe > PMAX) begin
            w_pq = '1;
        end else begin
            w_pq = w_pe[31:0];
        end
    end

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_do_out   = i_ctrl.exec && (i_ctrl.uw.alu == ALU_OUT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b0 <= 32'sd536870912;
            r_b1 <= '0;
            r_b2 <= '0;
            r_a1 <= '0;
            r_a2 <= '0;
            r_kp <= 32'd65536;
            r_ki <= '0;
            r_hp <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_B0:  r_b0 <= signed'(i_cfg_data);
                REG_B1:  r_b1 <= signed'(i_cfg_data);
                REG_B2:  r_b2 <= signed'(i_cfg_data);
                REG_A1:  r_a1 <= signed'(i_cfg_data);
                REG_A2:  r_a2 <= signed'(i_cfg_data);
                REG_KP:  r_kp <= i_cfg_data;
                REG_KI:  r_ki <= i_cfg_data;
                REG_HP:  r_hp <= i_cfg_data;
                default: r_kp <= r_kp;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_accept) begin
            r_op <= i_in_data.op;
            r_x  <= i_in_data.sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d1    <= '0;
            r_d2    <= '0;
            r_y1    <= '0;
            r_y2    <= '0;
            r_fprev <= '0;
            r_facc  <= '0;
            r_pprev <= '0;
            r_pacc  <= '0;
        end else if (i_ctrl.exec) begin
            case (i_ctrl.uw.alu)
                ALU_NOTCH: begin
                    r_y2 <= r_y1;
                    r_y1 <= w_ynew;
                    r_d2 <= r_d1;
                    r_d1 <= r_x;
                end
                ALU_KP:     r_fprev <= w_m;
                ALU_FREQ:   r_facc  <= sat_add(r_facc, w_m);
                ALU_TPH:    r_pprev <= r_v;
                ALU_PHASE:  r_pacc  <= sat_add(r_pacc, w_m);
                ALU_SUB2PI: r_pacc  <= w_psub;
                ALU_ADD2PI: r_pacc  <= w_padd;
                ALU_RESTART: begin
                    r_d1    <= '0;
                    r_d2    <= '0;
                    r_y1    <= '0;
                    r_y2    <= '0;
                    r_fprev <= '0;
                    r_pprev <= '0;
                    r_pacc  <= '0;
                    r_facc  <= AW'(r_x);
                end
                default: r_pacc <= r_pacc;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.exec) begin
            case (i_ctrl.uw.alu)
                ALU_ACC_LOAD: r_acc <= w_m;
                ALU_ACC_ADD:  r_acc <= sat_add(r_acc, w_m);
                ALU_KP: begin
                    r_kpin <= w_m;
                    r_t    <= sat_add(w_m, r_fprev);
                end
                ALU_VEL:      r_v <= sat_add(r_facc, r_kpin);
                ALU_TPH:      r_t <= sat_add(r_v, r_pprev);
                default:      r_acc <= r_acc;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_do_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_out) begin
            r_out.frequency      <= w_fq;
            r_out.phase          <= w_pq;
            r_out.filtered_error <= w_yq;
        end
    end

    always_comb begin
        o_stat.op       = r_op;
        o_stat.lt2pi    = (w_pacc_e < TWO_PI);
        o_stat.nonneg   = !r_pacc[AW-1];
        o_stat.out_free = w_out_free;
        o_stat.mul_done = w_mdone;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_out_from_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $rose(r_out_valid) |-> $past(w_do_out))
        else $error("result beat appeared without an output step");

endmodule
`default_nettype wire

[hw/rtl/srf_seq.sv]
`default_nettype none
module srf_seq import srf_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_accept,
    input  wire t_stat i_stat,
    output t_ctrl      o_ctrl,
    output logic       o_busy
);

    logic             r_busy;
    logic [PC_W-1:0]  r_pc;
    logic             r_mwait;

    t_uword           w_uw;
    logic             w_cond;
    logic             w_exec;
    logic             w_start;
    logic [PC_W-1:0]  n_pc;

    always_comb begin
        w_uw = ucode_rom(r_pc);
        case (w_uw.cond)
            C_NONE:   w_cond = 1'b0;
            C_ALWAYS: w_cond = 1'b1;
            C_OP:     w_cond = i_stat.op;
            C_LT2PI:  w_cond = i_stat.lt2pi;
            C_NONNEG: w_cond = i_stat.nonneg;
            default:  w_cond = 1'b0;
        endcase
        n_pc    = w_cond ? w_uw.target : r_pc + PC_W'(1);
        w_start = r_busy && w_uw.mul_en && !r_mwait;
        if (!r_busy) begin
            w_exec = 1'b0;
        end else if (w_uw.mul_en) begin
            w_exec = r_mwait && i_stat.mul_done;
        end else if (w_uw.alu == ALU_OUT) begin
            w_exec = i_stat.out_free;
        end else begin
            w_exec = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_pc    <= '0;
            r_mwait <= 1'b0;
        end else if (i_in_accept) begin
            r_busy  <= 1'b1;
            r_pc    <= '0;
            r_mwait <= 1'b0;
        end else if (r_busy) begin
            if (w_start) begin
                r_mwait <= 1'b1;
            end
            if (w_exec) begin
                r_mwait <= 1'b0;
                if (w_uw.alu == ALU_OUT) begin
                    r_busy <= 1'b0;
                end else begin
                    r_pc <= n_pc;
                end
            end
        end
    end

    always_comb begin
        o_ctrl.exec      = w_exec;
        o_ctrl.mul_start = w_start;
        o_ctrl.uw        = w_uw;
    end

    assign o_busy = r_busy;

    a_end_on_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $fell(r_busy) |-> $past(w_uw.alu == ALU_OUT))
        else $error("sequencer went idle outside the output step");

    a_mul_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_exec && w_uw.mul_en) |-> i_stat.mul_done)
        else $error("multiply step retired without a product");

endmodule
`default_nettype wire

[hw/rtl/srf_pll_with_notch.sv]
`default_nettype none
// Channel   Direction  Handshake                Beat
// in        input      i_in_valid / o_in_stall  i_in_data  (op, sample)
// out       output     o_out_valid / i_out_stall o_out_data (frequency, phase, filtered_error)
// cfg       input      i_cfg_we                 i_cfg_idx, i_cfg_data
//
// An input beat runs a microcoded program of up to 16 steps on one shared multiplier.
// Each of the eight products goes through a start step, one partial product per 24-bit chunk
// of the multiplicand, a saturation step and a retire step. A restart beat runs only the
// op check, restart and output steps. The next input beat is taken once the result has
// been loaded.
// Reset is synchronous and clears loop state and registers to their defaults; no clearing pass.
// A stalled result holds in the output register while the next beat is processed up to its
// output step.
module srf_pll_with_notch import srf_pkg::*; #(
    parameter int DATA_WIDTH = 32,
    parameter int ACC_WIDTH  = 48
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire t_in         i_in_data,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output t_out             o_out_data
);

    logic  w_busy;
    logic  w_in_accept;
    t_ctrl w_ctrl;
    t_stat w_stat;

    assign o_in_stall  = w_busy;
    assign w_in_accept = i_in_valid && !w_busy;

    srf_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_accept (w_in_accept),
        .i_stat      (w_stat),
        .o_ctrl      (w_ctrl),
        .o_busy      (w_busy)
    );

    srf_dpath #(
        .DATA_WIDTH (DATA_WIDTH),
        .ACC_WIDTH  (ACC_WIDTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_accept (w_in_accept),
        .i_in_data   (i_in_data),
        .i_ctrl      (w_ctrl),
        .i_out_stall (i_out_stall),
        .o_stat      (w_stat),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule
`default_nettype wire

[tb/srf_tb_pkg.sv]
`timescale 1ns / 1ps
package srf_tb_pkg;

    localparam logic OP_SAMPLE  = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    localparam logic [31:0] Q29_ONE = 32'h2000_0000;
    localparam logic [31:0] Q16_ONE = 32'h0001_0000;

endpackage

[tb/srf_checker.sv]
`timescale 1ns / 1ps
module srf_checker import srf_pkg::*, srf_tb_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_stall,
    input  wire t_in         i_in_data,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_stall,
    input  wire t_out        i_out_data,
    output int               o_mismatches,
    output int               o_outstanding,
    output int               o_checked,
    output int               o_wraps
);

    typedef logic signed [47:0] t_acc;
    typedef logic signed [33:0] t_coef;

    localparam t_acc ACC_MAX = {1'b0, {47{1'b1}}};
    localparam t_acc ACC_MIN = {1'b1, 47'd0};
    localparam t_acc TWO_PI  = {16'd0, F_2PI_Q29};

    logic [31:0] coef_b0, coef_b1, coef_b2, coef_a1, coef_a2;
    logic [31:0] gain_kp, gain_ki, half_ts;

    t_acc x_d1, x_d2, y_d1, y_d2;
    t_acc freq_in_d, freq_int, phase_in_d, phase_int;

    t_out pll_estimates_q[$];

    function automatic t_acc sat_sum(input t_acc a, input t_acc b);
        logic signed [48:0] s;
        s = a + b;
        if (s[48] != s[47]) begin
            return s[48] ? ACC_MIN : ACC_MAX;
        end
        return s[47:0];
    endfunction

    function automatic t_acc scaled_product(input t_acc a, input t_coef b, input int shift);
        logic signed [81:0] p;
        p = a * b;
        p = p >>> shift;
        if (p[81:47] != {35{p[81]}}) begin
            return p[81] ? ACC_MIN : ACC_MAX;
        end
        return p[47:0];
    endfunction

    function automatic logic signed [31:0] sat_word(input t_acc v);
        if (v[47:31] != {17{v[47]}}) begin
            return v[47] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        return v[31:0];
    endfunction

    function automatic t_coef signed_coef(input logic [31:0] v);
        return $signed(v);
    endfunction

    function automatic t_out predict_pll_step(input t_in beat);
        t_out  r;
        t_acc  x, sum, y, kp_term, vel;
        x = beat.sample;
        if (beat.op == OP_RESTART) begin
            x_d1 = '0;
            x_d2 = '0;
            y_d1 = '0;
            y_d2 = '0;
            freq_in_d = '0;
            phase_in_d = '0;
            phase_int = '0;
            freq_int = x;
            r.frequency = beat.sample;
            r.phase = '0;
            r.filtered_error = '0;
            return r;
        end
        sum = scaled_product(x, signed_coef(coef_b0), Q_NOTCH);
        sum = sat_sum(sum, scaled_product(x_d1, signed_coef(coef_b1), Q_NOTCH));
        sum = sat_sum(sum, scaled_product(x_d2, signed_coef(coef_b2), Q_NOTCH));
        sum = sat_sum(sum, scaled_product(y_d1, -signed_coef(coef_a1), Q_NOTCH));
        sum = sat_sum(sum, scaled_product(y_d2, -signed_coef(coef_a2), Q_NOTCH));
        y = sat_word(sum);
        y_d2 = y_d1;
        y_d1 = y;
        x_d2 = x_d1;
        x_d1 = x;

        kp_term = scaled_product(y, {2'b00, gain_kp}, Q_KP);
        freq_int = sat_sum(freq_int,
                           scaled_product(sat_sum(kp_term, freq_in_d), {2'b00, gain_ki}, Q_FREQ));
        freq_in_d = kp_term;

        vel = sat_sum(freq_int, kp_term);
        phase_int = sat_sum(phase_int,
                            scaled_product(sat_sum(vel, phase_in_d), {2'b00, half_ts}, Q_PHASE));
        phase_in_d = vel;

        // The phase is brought back into range by one correction at most.
        if (phase_int >= TWO_PI) begin
            phase_int = sat_sum(phase_int, -TWO_PI);
            o_wraps++;
        end
        if (phase_int < 0) begin
            phase_int = sat_sum(phase_int, TWO_PI);
            o_wraps++;
        end

        r.frequency = sat_word(freq_int);
        if (phase_int[47]) begin
            r.phase = '0;
        end else if (|phase_int[46:32]) begin
            r.phase = '1;
        end else begin
            r.phase = phase_int[31:0];
        end
        r.filtered_error = y[31:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            coef_b0 = Q29_ONE;
            coef_b1 = '0;
            coef_b2 = '0;
            coef_a1 = '0;
            coef_a2 = '0;
            gain_kp = Q16_ONE;
            gain_ki = '0;
            half_ts = '0;
            x_d1 = '0;
            x_d2 = '0;
            y_d1 = '0;
            y_d2 = '0;
            freq_in_d = '0;
            freq_int = '0;
            phase_in_d = '0;
            phase_int = '0;
            pll_estimates_q.delete();
            o_mismatches = 0;
            o_outstanding = 0;
            o_checked = 0;
            o_wraps = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (pll_estimates_q.size() == 0) begin
                    if (o_mismatches < 10) begin
                        $display("%0t: result beat with nothing expected: freq %h phase %h err %h",
                                 $realtime, i_out_data.frequency, i_out_data.phase,
                                 i_out_data.filtered_error);
                    end
                    o_mismatches++;
                end else begin
                    want = pll_estimates_q.pop_front();
                    o_checked++;
                    if (i_out_data.frequency != want.frequency
                            || i_out_data.phase != want.phase
                            || i_out_data.filtered_error != want.filtered_error) begin
                        if (o_mismatches < 10) begin
                            $display("%0t: result %0d differs (expected / actual):", $realtime,
                                     o_checked);
                            $display("  frequency      %h / %h", want.frequency,
                                     i_out_data.frequency);
                            $display("  phase          %h / %h", want.phase, i_out_data.phase);
                            $display("  filtered_error %h / %h", want.filtered_error,
                                     i_out_data.filtered_error);
                        end
                        o_mismatches++;
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_B0: coef_b0 = i_cfg_data;
                    REG_B1: coef_b1 = i_cfg_data;
                    REG_B2: coef_b2 = i_cfg_data;
                    REG_A1: coef_a1 = i_cfg_data;
                    REG_A2: coef_a2 = i_cfg_data;
                    REG_KP: gain_kp = i_cfg_data;
                    REG_KI: gain_ki = i_cfg_data;
                    REG_HP: half_ts = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                pll_estimates_q.push_back(predict_pll_step(i_in_data));
            end
            o_outstanding = pll_estimates_q.size();
        end
    end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;
    import srf_pkg::*;
    import srf_tb_pkg::*;

    localparam int STALL_LIMIT         = 5000;
    localparam int DRAIN_CYCLES        = 40;
    localparam int NUM_RANDOM_SETTINGS = 7;
    localparam int BEATS_PER_SETTING   = 55;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [2:0]  cfg_idx   = '0;
    logic [31:0] cfg_data  = '0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    t_in         in_data   = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    t_out        out_data;

    int mismatches, pending, checked, wraps;
    int beats_sent    = 0;
    int restarts_sent = 0;
    int settings_used = 0;
    bit quiet         = 1'b0;

    srf_pll_with_notch uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_data)
    );

    srf_checker pll_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .o_mismatches (mismatches),
        .o_outstanding(pending),
        .o_checked    (checked),
        .o_wraps      (wraps)
    );

    initial begin
        forever #1 clk = ~clk;
    end

    initial begin
        forever begin
            @(negedge clk);
            out_stall <= !quiet && ($urandom_range(0, 99) < 25);
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("No beat accepted for %0d cycles, giving up.", STALL_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    task automatic send_beat(input logic op, input logic [31:0] sample);
        @(negedge clk);
        while (!quiet && $urandom_range(0, 99) < 25) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid       <= 1'b1;
        in_data.op     <= op;
        in_data.sample <= sample;
        do @(posedge clk); while (in_stall);
        beats_sent++;
        if (op == OP_RESTART) begin
            restarts_sent++;
        end
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(posedge clk);
    endtask

    task automatic program_loop(input logic [31:0] b0, input logic [31:0] b1,
                                input logic [31:0] b2, input logic [31:0] a1,
                                input logic [31:0] a2, input logic [31:0] kp,
                                input logic [31:0] ki, input logic [31:0] hp);
        write_reg(REG_B0, b0);
        write_reg(REG_B1, b1);
        write_reg(REG_B2, b2);
        write_reg(REG_A1, a1);
        write_reg(REG_A2, a2);
        write_reg(REG_KP, kp);
        write_reg(REG_KI, ki);
        write_reg(REG_HP, hp);
        @(negedge clk);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    task automatic random_setting(input int kind);
        int b1;
        case (kind)
            0: begin
                program_loop(Q29_ONE, '0, '0, '0, '0, $urandom_range(1, 200) << 16,
                             $urandom_range(0, 1 << 28), $urandom_range(1 << 14, 1 << 22));
            end
            1: begin
                // A stable notch with its poles at radius 15/16.
                b1 = int'($urandom_range(0, 32'h8000_0000)) - 32'h4000_0000;
                program_loop(Q29_ONE, b1, Q29_ONE, b1 / 16 * 15, Q29_ONE / 256 * 225,
                             $urandom_range(1, 200) << 16, $urandom_range(0, 1 << 28),
                             $urandom_range(1 << 14, 1 << 22));
            end
            2: begin
                program_loop($urandom, $urandom, $urandom, $urandom, $urandom,
                             $urandom, $urandom, $urandom);
            end
            default: begin
                program_loop(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                             32'h8000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0001);
            end
        endcase
    endtask

    task automatic run_traffic(input int count);
        int n, len, amp, freq;
        n = 0;
        while (n < count) begin
            if ($urandom_range(0, 99) < 15) begin
                send_beat($urandom_range(0, 1), $urandom);
                n++;
            end else begin
                freq = int'($urandom_range(0, 16000)) - 8000;
                send_beat(OP_RESTART, freq * 65536);
                len = $urandom_range(4, 20);
                amp = 1 << $urandom_range(4, 20);
                repeat (len) begin
                    send_beat(OP_SAMPLE, int'($urandom_range(0, 2 * amp)) - amp);
                end
                n += len + 1;
            end
        end
    endtask

    initial begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_beat(OP_SAMPLE, 32'h0000_0000);
        send_beat(OP_SAMPLE, 32'h7FFF_FFFF);
        send_beat(OP_SAMPLE, 32'h8000_0000);
        send_beat(OP_SAMPLE, 32'hFFFF_FFFF);
        send_beat(OP_RESTART, 32'h7FFF_FFFF);
        send_beat(OP_SAMPLE, 32'h0000_0001);
        send_beat(OP_RESTART, 32'h8000_0000);
        send_beat(OP_SAMPLE, Q16_ONE);

        // Every coefficient and gain at full scale drives all accumulators into saturation.
        wait_idle();
        program_loop(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                     32'h7FFF_FFFF, '1, '1, '1);
        send_beat(OP_SAMPLE, 32'h7FFF_FFFF);
        send_beat(OP_SAMPLE, 32'h8000_0000);
        send_beat(OP_SAMPLE, 32'h7FFF_FFFF);
        send_beat(OP_SAMPLE, 32'h8000_0000);
        send_beat(OP_RESTART, 32'h0000_0000);
        send_beat(OP_SAMPLE, 32'h7FFF_FFFF);
        send_beat(OP_SAMPLE, 32'h8000_0000);

        // A fast loop that wraps the phase on nearly every beat, in both directions.
        wait_idle();
        program_loop(Q29_ONE, '0, '0, '0, '0, 10 << 16, 214748365, 2147484);
        send_beat(OP_RESTART, 6000 * 65536);
        send_beat(OP_SAMPLE, 32'h0000_0000);
        send_beat(OP_SAMPLE, Q16_ONE);
        send_beat(OP_SAMPLE, -Q16_ONE);
        send_beat(OP_RESTART, -6000 * 65536);
        send_beat(OP_SAMPLE, 32'h0000_0000);
        send_beat(OP_SAMPLE, Q16_ONE);

        for (int s = 0; s < NUM_RANDOM_SETTINGS; s++) begin
            quiet = (s == 3);
            wait_idle();
            random_setting(s % 4);
            run_traffic(BEATS_PER_SETTING);
        end
        quiet = 1'b0;
        wait_idle();

        $display("Sent %0d beats (%0d restarts) under %0d register settings.",
                 beats_sent, restarts_sent, settings_used);
        $display("Checked %0d results; the phase wrapped %0d times.", checked, wraps);
        if (mismatches == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("%0d mismatches, %0d results still outstanding.", mismatches, pending);
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
